@@ sv/tfl_pkg.sv @@
// Shared types and codes for the talker floor lock.
`timescale 1ns / 1ps

package tfl_pkg;

    // Request types
    localparam logic [1:0] REQ_CHUNK = 2'd0;
    localparam logic [1:0] REQ_META  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Verdict codes
    localparam logic [2:0] VERDICT_ACCEPTED     = 3'd0;
    localparam logic [2:0] VERDICT_OWN_DEVICE   = 3'd1;
    localparam logic [2:0] VERDICT_OTHER_TALKER = 3'd2;
    localparam logic [2:0] VERDICT_OLD_SEQUENCE = 3'd3;
    localparam logic [2:0] VERDICT_META_NOP     = 3'd4;
    localparam logic [2:0] VERDICT_RELEASED     = 3'd5;
    localparam logic [2:0] VERDICT_CLEARED      = 3'd6;

    // Configuration register indexes
    localparam logic CFG_IDLE_TIMEOUT = 1'b0;
    localparam logic CFG_OWN_DEVICE   = 1'b1;

    localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd1000;
    localparam logic [31:0] OWN_DEVICE_RESET   = 32'd0;

    typedef struct packed {
        logic        locked;
        logic [31:0] dev;
        logic        has_dev;
        logic [31:0] sess;
        logic [31:0] last_time;
        logic        have_seq;
        logic [31:0] last_seq;
    } lock_state_t;

    localparam lock_state_t LOCK_STATE_IDLE = '0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic [31:0] dev_token;
        logic        has_device;
        logic [31:0] session_id;
        logic        has_session;
        logic [31:0] sequence_req;
        logic        has_active;
        logic        active;
    } event_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       timed_out;
        logic       talker_locked;
    } result_t;

endpackage

@@ sv/tfl_step.sv @@
// Combinational update of the floor lock for one event.
`timescale 1ns / 1ps

module tfl_step
    import tfl_pkg::*;
(
    input  event_t      evt,
    input  lock_state_t state_cur,
    input  logic [31:0] idle_timeout_ms,
    input  logic [31:0] own_dev_token,
    output lock_state_t state_nxt,
    output result_t     res
);

    logic [31:0] elapsed;
    logic [31:0] dev;
    logic        expire;
    logic        smatch;
    logic        dmatch;
    lock_state_t st;

    assign elapsed = evt.now_ms - state_cur.last_time;
    assign expire  = state_cur.locked && (elapsed > idle_timeout_ms);
    // absent device token reads as zero
    assign dev     = evt.has_device ? evt.dev_token : 32'd0;

    always_comb begin
        st            = expire ? LOCK_STATE_IDLE : state_cur;
        res.verdict   = VERDICT_META_NOP;
        res.timed_out = expire;
        smatch        = !evt.has_session || (evt.session_id == st.sess);
        dmatch        = !evt.has_device || !st.has_dev || (dev == st.dev);

        unique case (evt.req_type)
            REQ_CHUNK: begin
                if (evt.has_device && (dev == own_dev_token)) begin
                    res.verdict = VERDICT_OWN_DEVICE;
                end else if (!st.locked) begin
                    // seize: the first chunk passes unless it comes from the own device
                    st.locked    = 1'b1;
                    st.dev       = dev;
                    st.has_dev   = evt.has_device;
                    st.sess      = evt.session_id;
                    st.last_time = evt.now_ms;
                    st.have_seq  = 1'b1;
                    st.last_seq  = evt.sequence_req;
                    res.verdict  = VERDICT_ACCEPTED;
                end else if ((evt.session_id != st.sess) ||
                             (st.has_dev && evt.has_device && (dev != st.dev))) begin
                    res.verdict = VERDICT_OTHER_TALKER;
                end else if (st.have_seq && (evt.sequence_req <= st.last_seq)) begin
                    res.verdict = VERDICT_OLD_SEQUENCE;
                end else begin
                    st.last_time = evt.now_ms;
                    st.have_seq  = 1'b1;
                    st.last_seq  = evt.sequence_req;
                    res.verdict  = VERDICT_ACCEPTED;
                end
            end
            REQ_META: begin
                if (evt.has_active && !evt.active && st.locked && smatch && dmatch) begin
                    st          = LOCK_STATE_IDLE;
                    res.verdict = VERDICT_RELEASED;
                end
            end
            REQ_CLEAR: begin
                st          = LOCK_STATE_IDLE;
                res.verdict = VERDICT_CLEARED;
            end
            default: begin
                // undefined type: only the idle check applies
                res.verdict = VERDICT_META_NOP;
            end
        endcase

        res.talker_locked = st.locked;
        state_nxt         = st;
    end

endmodule

@@ sv/talker_floor_lock.sv @@
// Top level of the talker floor lock: word registers, lock state, config.
//
//  channel | ports             | role
//  --------+-------------------+-----------------------------------------
//  event   | s_valid / s_ready | chunk, meta and clear words in
//  result  | m_valid / m_ready | verdict, timed_out, lock state out
//  config  | cfg_we            | idle timeout (0), own device token (1)
//
// One word per cycle unless the result stalls; path: input register, result register.
// The lock state is updated as a word moves from the input to the result
// register, so each word sees all earlier ones.
// aresetn (synchronous) frees the lock and restores register defaults.
// A stalled result holds; the input register takes words while it is empty
// or while the result register is free or being emptied.
`timescale 1ns / 1ps

module talker_floor_lock
    import tfl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_now_ms,
    input  logic [31:0] s_dev_token,
    input  logic        s_has_device,
    input  logic [31:0] s_session_id,
    input  logic        s_has_session,
    input  logic [31:0] s_sequence_req,
    input  logic        s_has_active,
    input  logic        s_active,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_verdict,
    output logic        m_timed_out,
    output logic        m_talker_locked_out
);

    logic [31:0] idle_timeout_reg;
    logic [31:0] own_device_reg;

    event_t      in_word_reg;
    logic        in_valid_reg;
    result_t     res_reg;
    logic        res_valid_reg;
    lock_state_t lock_reg;
    lock_state_t lock_next;
    result_t     res_next;
    logic        res_free;
    logic        advance;

    assign res_free = !res_valid_reg || m_ready;
    assign advance  = in_valid_reg && res_free;
    assign s_ready  = !in_valid_reg || res_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
            own_device_reg   <= OWN_DEVICE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_wdata;
                CFG_OWN_DEVICE:   own_device_reg   <= cfg_wdata;
                default:          idle_timeout_reg <= idle_timeout_reg;
            endcase
        end
    end

    // input word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= '{req_type:     s_req_type,
                             now_ms:       s_now_ms,
                             dev_token:    s_dev_token,
                             has_device:   s_has_device,
                             session_id:   s_session_id,
                             has_session:  s_has_session,
                             sequence_req: s_sequence_req,
                             has_active:   s_has_active,
                             active:       s_active};
        end
    end

    tfl_step u_step (
        .evt             (in_word_reg),
        .state_cur       (lock_reg),
        .idle_timeout_ms (idle_timeout_reg),
        .own_dev_token   (own_device_reg),
        .state_nxt       (lock_next),
        .res             (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg      <= LOCK_STATE_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                lock_reg <= lock_next;
            end
            if (res_free) begin
                res_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid             = res_valid_reg;
    assign m_verdict           = res_reg.verdict;
    assign m_timed_out         = res_reg.timed_out;
    assign m_talker_locked_out = res_reg.talker_locked;

endmodule

@@ sv/tfl_checker.sv @@
// Port-level checks for the talker floor lock, bound to the top level.
`timescale 1ns / 1ps

module tfl_checker
    import tfl_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_verdict,
    input logic       m_timed_out,
    input logic       m_talker_locked_out
);

    // stalled result word holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_verdict)
            && $stable(m_timed_out) && $stable(m_talker_locked_out))
        else $error("result word changed while stalled");

    a_accept_locks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_verdict == VERDICT_ACCEPTED) |-> m_talker_locked_out)
        else $error("accepted chunk left the lock free");

    a_release_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && ((m_verdict == VERDICT_RELEASED) || (m_verdict == VERDICT_CLEARED))
            |-> !m_talker_locked_out)
        else $error("release or clear left the lock held");

    a_verdict_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_verdict <= VERDICT_CLEARED))
        else $error("verdict code out of range");

endmodule

bind talker_floor_lock tfl_checker u_tfl_checker (.*);
